[hdl/fqs_pkg.sv]
// Package with the shared types, codes and sizes of the searchable queue.
package fqs_pkg;

   // Number of elements the queue can hold.
   localparam int DEPTH = 16;
   // Width of a cell index and of the element count.
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Operation codes.
   localparam logic [2:0] OP_ENQ    = 3'd0;
   localparam logic [2:0] OP_DEQ    = 3'd1;
   localparam logic [2:0] OP_PEEK   = 3'd2;
   localparam logic [2:0] OP_SEARCH = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   // Status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Request payload.
   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] value;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic signed [31:0] data_out;
      logic               found;
      logic [3:0]         position;
      logic [1:0]         status;
      logic [4:0]         count;
   } rsp_type;

   // Per-cell control: take the neighbour's element, or load the new one.
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

[hdl/fqs_cell.sv]
// One storage cell of the queue: holds one element and compares it with the key.
module fqs_cell (
   input  logic                  clock,
   input  fqs_pkg::cell_ctl_type ctl,
   input  logic signed [31:0]    value,
   input  logic signed [31:0]    next_data,
   output logic signed [31:0]    data,
   output logic                  match
);

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;

   // A dequeue moves every element one cell towards the front; an enqueue
   // writes the first free cell.
   always_comb begin
      priority if (ctl.shift) begin
         data_in = next_data;
      end else if (ctl.load) begin
         data_in = value;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign match = (data_ff == value);

endmodule

[hdl/fifo_queue_with_search.sv]
// Top level of the searchable queue: control, the row of cells and the response register.
//
//  Channel | Ports                                | Payload
//  --------+--------------------------------------+---------------------------
//  request | req_valid, req_ready, req_data       | opcode, value
//  response| rsp_valid, rsp_ready, rsp_data       | data_out, found, position,
//          |                                      | status, count
//
// Every operation is accepted and its response is registered at the same edge. Cell 0
// always holds the front element, so search is a compare in every cell followed by a
// priority pick of the lowest matching cell.
// A new request is taken outside reset whenever the response register is empty or
// being drained. Synchronous reset empties the queue and the response register;
// cell contents are not reset and are only read once written.
module fifo_queue_with_search (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fqs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fqs_pkg::rsp_type rsp_data
);

   logic [fqs_pkg::CNT_W-1:0] held_ff;
   logic [fqs_pkg::CNT_W-1:0] held_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   fqs_pkg::rsp_type          rsp_ff;
   fqs_pkg::rsp_type          rsp_in;

   logic                      accept;
   logic                      is_full;
   logic                      is_empty;
   logic signed [31:0]        cell_data [fqs_pkg::DEPTH];
   logic [fqs_pkg::DEPTH-1:0] cell_match;
   fqs_pkg::cell_ctl_type     cell_ctl [fqs_pkg::DEPTH];
   logic                      hit;
   logic [fqs_pkg::IDX_W-1:0] hit_idx;

   // A transfer is taken outside reset while the response register is free or being drained.
   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign is_full   = (held_ff == fqs_pkg::CNT_W'(fqs_pkg::DEPTH));
   assign is_empty  = (held_ff == '0);

   // The row of cells, each fed by its neighbour towards the back.
   for (genvar i = 0; i < fqs_pkg::DEPTH; i++) begin : g_cell
      logic signed [31:0] nxt;
      if (i == fqs_pkg::DEPTH - 1) begin : g_last
         assign nxt = cell_data[i];
      end else begin : g_mid
         assign nxt = cell_data[i+1];
      end

      assign cell_ctl[i].shift = accept && (req_data.opcode == fqs_pkg::OP_DEQ) && !is_empty;
      assign cell_ctl[i].load  = accept && (req_data.opcode == fqs_pkg::OP_ENQ) && !is_full
                                 && (held_ff == fqs_pkg::CNT_W'(i));

      fqs_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl[i]),
         .value     (req_data.value),
         .next_data (nxt),
         .data      (cell_data[i]),
         .match     (cell_match[i])
      );
   end

   // Lowest occupied cell that matches the key; later cells are overridden.
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = fqs_pkg::DEPTH - 1; i >= 0; i--) begin
         if (cell_match[i] && (fqs_pkg::CNT_W'(i) < held_ff)) begin
            hit     = 1'b1;
            hit_idx = fqs_pkg::IDX_W'(i);
         end
      end
   end

   // Next count and response fields for the operation on offer.
   always_comb begin
      held_in         = held_ff;
      rsp_in          = '0;
      unique case (req_data.opcode)
         fqs_pkg::OP_ENQ: begin
            if (is_full) begin
               rsp_in.status = fqs_pkg::ST_FULL;
            end else begin
               held_in = held_ff + 1'b1;
            end
         end
         fqs_pkg::OP_DEQ, fqs_pkg::OP_PEEK: begin
            if (is_empty) begin
               rsp_in.status = fqs_pkg::ST_EMPTY;
            end else begin
               rsp_in.data_out = cell_data[0];
               if (req_data.opcode == fqs_pkg::OP_DEQ) begin
                  held_in = held_ff - 1'b1;
               end
            end
         end
         fqs_pkg::OP_SEARCH: begin
            rsp_in.found    = hit;
            rsp_in.position = 4'(hit_idx);
         end
         fqs_pkg::OP_CLEAR: begin
            held_in = '0;
         end
         default: begin
            held_in = held_ff;
         end
      endcase
      rsp_in.count = 5'(held_in);
   end

   // Response valid flag: set by a request transfer, cleared by a response transfer.
   always_comb begin
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            held_ff <= held_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload, loaded on each request transfer.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // The count never exceeds the queue depth.
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= fqs_pkg::CNT_W'(fqs_pkg::DEPTH))
      else $error("queue count above depth");

   // A pending response reports the count the queue now holds.
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.count == 5'(held_ff)))
      else $error("response count differs from queue count");

   // An enqueue into a queue with room grows the count by one.
   a_enq_grow: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.opcode == fqs_pkg::OP_ENQ) && !is_full)
      |=> (held_ff == $past(held_ff) + 1'b1))
      else $error("enqueue did not grow the queue");

   // Only a search can report a match.
   a_found_search: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.opcode != fqs_pkg::OP_SEARCH)) |=> !rsp_ff.found)
      else $error("match reported for a non-search operation");

   // A clear empties the queue.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.opcode == fqs_pkg::OP_CLEAR)) |=> (held_ff == '0))
      else $error("clear left elements in the queue");
`endif

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the searchable first-in first-out queue.
`timescale 1ns / 1ps

module tb_top;

   // Opcodes five to seven are spare and must leave the queue alone.
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_MID   = 3'd6;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   localparam int RANDOM_ITEMS = 1500;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int MAX_REPORTS  = 10;

   // Kinds of random traffic, each biased towards one region of behaviour.
   typedef enum int {
      MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_SEARCH, MODE_NOISE
   } traffic_mode_type;

   // One row of the directed table: an operation, how often to repeat it
   // (the value steps by one per repeat) and, where obvious, the typed response.
   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] value;
      logic [4:0]         reps;
      logic               pinned;
      fqs_pkg::rsp_type   want;
   } step_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   fqs_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   fqs_pkg::rsp_type rsp_data;

   // Typed expectation travelling alongside the request being offered.
   logic             pin_flag = 1'b0;
   fqs_pkg::rsp_type pin_rsp = '0;

   // Shadow of the queue contents, front first, and the responses still owed.
   logic signed [31:0] queue_shadow[$];
   fqs_pkg::rsp_type   owed_rsps[$];
   logic signed [31:0] recent_vals[$];

   int errors = 0;
   int rsp_seen = 0;
   int rsp_stall = 0;
   bit rsp_calm = 1'b0;
   bit sender_calm = 1'b0;

   fifo_queue_with_search dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Give up if the run hangs.
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Apply one operation to the shadow queue and return the response it should give.
   function automatic fqs_pkg::rsp_type queue_op_result(input fqs_pkg::req_type rq);
      fqs_pkg::rsp_type r;
      r = '0;
      case (rq.opcode)
         fqs_pkg::OP_ENQ: begin
            if (queue_shadow.size() >= fqs_pkg::DEPTH) r.status = fqs_pkg::ST_FULL;
            else queue_shadow.push_back(rq.value);
         end
         fqs_pkg::OP_DEQ, fqs_pkg::OP_PEEK: begin
            if (queue_shadow.size() == 0) begin
               r.status = fqs_pkg::ST_EMPTY;
            end else begin
               r.data_out = queue_shadow[0];
               if (rq.opcode == fqs_pkg::OP_DEQ) void'(queue_shadow.pop_front());
            end
         end
         fqs_pkg::OP_SEARCH: begin
            for (int k = 0; k < queue_shadow.size(); k++) begin
               if (queue_shadow[k] == rq.value) begin
                  r.found    = 1'b1;
                  r.position = 4'(k);
                  break;
               end
            end
         end
         fqs_pkg::OP_CLEAR: queue_shadow.delete();
         default: ;
      endcase
      r.count = 5'(queue_shadow.size());
      return r;
   endfunction

   function automatic fqs_pkg::rsp_type mk_rsp(input logic signed [31:0] data,
                                               input logic found, input logic [3:0] pos,
                                               input logic [1:0] status,
                                               input logic [4:0] count);
      fqs_pkg::rsp_type r;
      r.data_out = data;
      r.found    = found;
      r.position = pos;
      r.status   = status;
      r.count    = count;
      return r;
   endfunction

   task automatic flag_error(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%s", msg);
   endtask

   // Compare a received response field by field with the oldest one owed.
   task automatic check_rsp(input fqs_pkg::rsp_type got, input fqs_pkg::rsp_type want);
      if (got.data_out !== want.data_out)
         flag_error($sformatf("response %0d: data_out expected %0d, got %0d",
                              rsp_seen, want.data_out, got.data_out));
      if (got.found !== want.found)
         flag_error($sformatf("response %0d: found expected %0d, got %0d",
                              rsp_seen, want.found, got.found));
      if (got.position !== want.position)
         flag_error($sformatf("response %0d: position expected %0d, got %0d",
                              rsp_seen, want.position, got.position));
      if (got.status !== want.status)
         flag_error($sformatf("response %0d: status expected %0d, got %0d",
                              rsp_seen, want.status, got.status));
      if (got.count !== want.count)
         flag_error($sformatf("response %0d: count expected %0d, got %0d",
                              rsp_seen, want.count, got.count));
   endtask

   // Predict on every request transfer and check every response transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            fqs_pkg::rsp_type predicted;
            predicted = queue_op_result(req_data);
            owed_rsps.push_back(pin_flag ? pin_rsp : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_rsps.size() == 0)
               flag_error($sformatf("response %0d arrived with none outstanding", rsp_seen));
            else
               check_rsp(rsp_data, owed_rsps.pop_front());
            rsp_seen++;
         end
      end
   end

   // Most stalls are short, a few are long.
   function automatic int pick_stall();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Response side back-pressure, with calm stretches where it always accepts.
   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!rsp_calm && $urandom_range(0, 99) < 15) rsp_stall <= pick_stall();
      end
      if ($urandom_range(0, 199) == 0) rsp_calm <= !rsp_calm;
   end

   function automatic int pick_gap();
      if (sender_calm || $urandom_range(0, 99) < 60) return 0;
      return pick_stall();
   endfunction

   // Offer one request and hold it until the transfer happens.
   task automatic send_item(input fqs_pkg::req_type item, input logic pinned,
                            input fqs_pkg::rsp_type want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      pin_flag  <= pinned;
      pin_rsp   <= want;
      do @(posedge clock); while (!(req_valid && req_ready));
      if ($urandom_range(0, 79) == 0) sender_calm = !sender_calm;
   endtask

   // Stop offering requests until every owed response has come back or the limit is reached.
   task automatic wait_drained(input int limit);
      int n;
      n = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_rsps.size() != 0 && n < limit) begin
         @(posedge clock);
         n++;
      end
   endtask

   // Values are often small or reused so that searches hit and find duplicates.
   function automatic logic signed [31:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return $signed(32'($urandom_range(0, 7))) - 4;
      if (roll < 65 && recent_vals.size() != 0)
         return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
      if (roll < 70) return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      return $signed($urandom());
   endfunction

   function automatic fqs_pkg::req_type random_item(input traffic_mode_type mode);
      fqs_pkg::req_type rq;
      int roll;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_FILL:
            rq.opcode = (roll < 75) ? fqs_pkg::OP_ENQ :
                        (roll < 90) ? fqs_pkg::OP_SEARCH :
                        (roll < 97) ? fqs_pkg::OP_PEEK : fqs_pkg::OP_DEQ;
         MODE_DRAIN:
            rq.opcode = (roll < 70) ? fqs_pkg::OP_DEQ :
                        (roll < 85) ? fqs_pkg::OP_PEEK :
                        (roll < 95) ? fqs_pkg::OP_SEARCH : fqs_pkg::OP_ENQ;
         MODE_MIXED:
            rq.opcode = (roll < 40) ? fqs_pkg::OP_ENQ :
                        (roll < 70) ? fqs_pkg::OP_DEQ :
                        (roll < 80) ? fqs_pkg::OP_PEEK :
                        (roll < 97) ? fqs_pkg::OP_SEARCH : fqs_pkg::OP_CLEAR;
         MODE_SEARCH:
            rq.opcode = (roll < 60) ? fqs_pkg::OP_SEARCH :
                        (roll < 80) ? fqs_pkg::OP_ENQ :
                        (roll < 95) ? fqs_pkg::OP_DEQ : fqs_pkg::OP_PEEK;
         default:
            rq.opcode = (roll < 30) ? 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)) :
                        (roll < 45) ? fqs_pkg::OP_CLEAR : 3'($urandom());
      endcase
      if (rq.opcode == fqs_pkg::OP_ENQ || rq.opcode == fqs_pkg::OP_SEARCH)
         rq.value = pick_value();
      else
         rq.value = $signed($urandom());
      if (rq.opcode == fqs_pkg::OP_ENQ) begin
         recent_vals.push_back(rq.value);
         if (recent_vals.size() > 32) void'(recent_vals.pop_front());
      end
      return rq;
   endfunction

   initial begin
      step_row_type     dir_rows [0:22];
      fqs_pkg::req_type item;
      traffic_mode_type mode;
      int               sent;
      int               seg;

      // Empty queue, extremes of the value, spare opcodes, fill to full,
      // dequeue and refill, and clear.
      dir_rows = '{
         '{fqs_pkg::OP_DEQ,    32'sd0,        5'd1,  1'b1,
           mk_rsp(0, 0, 0, fqs_pkg::ST_EMPTY, 0)},
         '{fqs_pkg::OP_PEEK,   32'sd0,        5'd1,  1'b1,
           mk_rsp(0, 0, 0, fqs_pkg::ST_EMPTY, 0)},
         '{fqs_pkg::OP_SEARCH, 32'sd0,        5'd1,  1'b1,
           mk_rsp(0, 0, 0, fqs_pkg::ST_OK, 0)},
         '{OP_SPARE_FIRST,     -32'sd1,       5'd1,  1'b1,
           mk_rsp(0, 0, 0, fqs_pkg::ST_OK, 0)},
         '{fqs_pkg::OP_ENQ,    32'sh7FFFFFFF, 5'd1,  1'b1,
           mk_rsp(0, 0, 0, fqs_pkg::ST_OK, 1)},
         '{fqs_pkg::OP_ENQ,    32'sh80000000, 5'd1,  1'b1,
           mk_rsp(0, 0, 0, fqs_pkg::ST_OK, 2)},
         '{fqs_pkg::OP_PEEK,   32'sd0,        5'd1,  1'b1,
           mk_rsp(32'sh7FFFFFFF, 0, 0, fqs_pkg::ST_OK, 2)},
         '{fqs_pkg::OP_SEARCH, 32'sh80000000, 5'd1,  1'b1,
           mk_rsp(0, 1, 1, fqs_pkg::ST_OK, 2)},
         '{fqs_pkg::OP_SEARCH, 32'sd0,        5'd1,  1'b1,
           mk_rsp(0, 0, 0, fqs_pkg::ST_OK, 2)},
         '{OP_SPARE_LAST,      32'sh5A5A5A5A, 5'd1,  1'b1,
           mk_rsp(0, 0, 0, fqs_pkg::ST_OK, 2)},
         '{fqs_pkg::OP_DEQ,    32'sd0,        5'd1,  1'b1,
           mk_rsp(32'sh7FFFFFFF, 0, 0, fqs_pkg::ST_OK, 1)},
         '{fqs_pkg::OP_ENQ,    32'sd1,        5'd15, 1'b0, '0},
         '{fqs_pkg::OP_ENQ,    32'sh55,       5'd1,  1'b1,
           mk_rsp(0, 0, 0, fqs_pkg::ST_FULL, 16)},
         '{fqs_pkg::OP_SEARCH, 32'sd15,       5'd1,  1'b0, '0},
         '{fqs_pkg::OP_DEQ,    32'sd0,        5'd3,  1'b0, '0},
         '{fqs_pkg::OP_ENQ,    32'shA5A5A5A5, 5'd3,  1'b0, '0},
         '{fqs_pkg::OP_SEARCH, 32'shA5A5A5A7, 5'd1,  1'b0, '0},
         '{OP_SPARE_MID,       32'sd0,        5'd1,  1'b0, '0},
         '{fqs_pkg::OP_CLEAR,  32'sd0,        5'd1,  1'b1,
           mk_rsp(0, 0, 0, fqs_pkg::ST_OK, 0)},
         '{fqs_pkg::OP_PEEK,   32'sd0,        5'd1,  1'b1,
           mk_rsp(0, 0, 0, fqs_pkg::ST_EMPTY, 0)},
         '{fqs_pkg::OP_ENQ,    -32'sd1,       5'd1,  1'b1,
           mk_rsp(0, 0, 0, fqs_pkg::ST_OK, 1)},
         '{fqs_pkg::OP_SEARCH, -32'sd1,       5'd1,  1'b1,
           mk_rsp(0, 1, 0, fqs_pkg::ST_OK, 1)},
         '{fqs_pkg::OP_CLEAR,  32'sd0,        5'd1,  1'b1,
           mk_rsp(0, 0, 0, fqs_pkg::ST_OK, 0)}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (dir_rows[i]) begin
         for (int r = 0; r < dir_rows[i].reps; r++) begin
            item.opcode = dir_rows[i].opcode;
            item.value  = dir_rows[i].value + r;
            send_item(item, dir_rows[i].pinned, dir_rows[i].want);
         end
      end
      wait_drained(DRAIN_LIMIT);

      // Random traffic in segments of one mode each, with a full pause half way.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         mode = traffic_mode_type'($urandom_range(MODE_FILL, MODE_NOISE));
         seg  = $urandom_range(8, 40);
         repeat (seg) begin
            send_item(random_item(mode), 1'b0, '0);
            sent++;
            if (sent == RANDOM_ITEMS / 2) wait_drained(DRAIN_LIMIT);
         end
      end

      wait_drained(DRAIN_LIMIT);
      repeat (10) @(posedge clock);
      if (owed_rsps.size() != 0)
         flag_error($sformatf("%0d responses never arrived", owed_rsps.size()));

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
